FILE: hdl/firmware_download_descrambler_unit_defines.svh
// Assertion macros shared by the descrambler RTL.
// Used by the top level only; no other dependencies.
`ifndef FIRMWARE_DOWNLOAD_DESCRAMBLER_UNIT_DEFINES_SVH
`define FIRMWARE_DOWNLOAD_DESCRAMBLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FDD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FDD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FDD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/fdd_pkg.sv
// Types and constants of the firmware download descrambler.
// No dependencies; imported by every module of the block.
package fdd_pkg;

   localparam int PACKET_BYTES_DEF = 64;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int CMD_DEPTH        = 12;

   localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
   localparam logic [31:0] KEY_RESET = 32'h2EB5_040B;
   localparam logic [8:0]  SIZE_MASK = 9'd511;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_FLASH   = 3'd1;
   localparam logic [2:0] KIND_BADSIZE = 3'd2;
   localparam logic [2:0] KIND_VERSION = 3'd3;
   localparam logic [2:0] KIND_BOOT    = 3'd4;
   localparam logic [2:0] KIND_DONE    = 3'd5;

   localparam int FLASH_LEN   = 7;
   localparam int FLASH_MIN   = 9;
   localparam int VERSION_LEN = 12;
   localparam int BOOT_LEN    = 6;

   localparam logic [7:0] PAT_FLASH [FLASH_LEN] =
      '{8'h3A, 8'h46, 8'h4C, 8'h41, 8'h53, 8'h48, 8'h0A};
   localparam logic [7:0] PAT_VERSION [VERSION_LEN] =
      '{8'h3A, 8'h47, 8'h45, 8'h54, 8'h56, 8'h45, 8'h52, 8'h53, 8'h49, 8'h4F, 8'h4E, 8'h0A};
   localparam logic [7:0] PAT_BOOT [BOOT_LEN] =
      '{8'h3A, 8'h42, 8'h4F, 8'h4F, 8'h54, 8'h0A};

   // One queued input byte's worth of results: an optional flash byte,
   // then an optional trailing status result.
   typedef struct packed {
      logic        flash;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [2:0]  tail;
   } entry_type;

endpackage

FILE: hdl/fdd_front.sv
// Front end: accepts packet bytes, parses commands, descrambles download data.
// Depends on fdd_pkg; feeds fdd_queue.
module fdd_front
   import fdd_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_in_packet
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   localparam int PW = $clog2(PACKET_BYTES + 1);

   logic [31:0] key_ff;
   logic        mode_ff, mode_in;
   logic [31:0] lfsr_ff, lfsr_in;
   logic [15:0] size_ff, size_in;
   logic [16:0] offset_ff, offset_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]  cmd_ff [CMD_DEPTH];
   logic [7:0]  cmd_view [CMD_DEPTH];

   logic          fire, acc;
   logic [PW-1:0] pos_inc, len;
   logic [31:0]   lfsr_step;
   logic [16:0]   off_inc, off_after;
   logic [15:0]   cmd_size;
   logic          match_flash, match_version, match_boot;
   entry_type     entry;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign acc        = pos_ff < PW'(PACKET_BYTES);
   assign pos_inc    = pos_ff + 1'b1;
   assign len        = acc ? pos_inc : pos_ff;
   assign lfsr_step  = {1'b0, lfsr_ff[31:1]} ^ ({32{lfsr_ff[0]}} & LFSR_TAPS);
   assign off_inc    = offset_ff + 17'd1;
   assign off_after  = acc ? off_inc : offset_ff;

   // Command bytes as they stand once the current beat is stored.
   always_comb begin
      for (int i = 0; i < CMD_DEPTH; i++) begin
         cmd_view[i] = (acc && pos_ff == PW'(i)) ? req_tdata : cmd_ff[i];
      end
   end

   assign cmd_size = {cmd_view[8], cmd_view[7]};

   // Length checks keep bytes of earlier packets out of the compare.
   always_comb begin
      match_flash   = len >= PW'(FLASH_MIN);
      match_version = len >= PW'(VERSION_LEN);
      match_boot    = len >= PW'(BOOT_LEN);
      for (int i = 0; i < FLASH_LEN; i++) begin
         if (cmd_view[i] != PAT_FLASH[i]) match_flash = 1'b0;
      end
      for (int i = 0; i < VERSION_LEN; i++) begin
         if (cmd_view[i] != PAT_VERSION[i]) match_version = 1'b0;
      end
      for (int i = 0; i < BOOT_LEN; i++) begin
         if (cmd_view[i] != PAT_BOOT[i]) match_boot = 1'b0;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      lfsr_in   = lfsr_ff;
      size_in   = size_ff;
      offset_in = offset_ff;
      pos_in    = pos_ff;
      entry     = '0;
      entry.tail = KIND_NONE;
      if (fire) begin
         pos_in = req_tlast ? '0 : len;
         if (mode_ff) begin
            if (acc) begin
               lfsr_in    = lfsr_step;
               entry.flash = 1'b1;
               entry.addr  = offset_ff[15:0];
               entry.data  = req_tdata ^ lfsr_step[7:0];
               offset_in   = off_inc;
            end
            if (req_tlast && off_after >= {1'b0, size_ff}) begin
               entry.tail = KIND_DONE;
               offset_in  = '0;
               mode_in    = 1'b0;
            end
         end else if (req_tlast) begin
            priority if (match_flash) begin
               size_in = cmd_size;
               if ((cmd_size[8:0] & SIZE_MASK) != 9'd0) begin
                  entry.tail = KIND_BADSIZE;
               end else begin
                  mode_in   = 1'b1;
                  offset_in = '0;
                  lfsr_in   = (key_ff == 32'd0) ? 32'd1 : key_ff;
               end
            end else if (match_version) begin
               entry.tail = KIND_VERSION;
            end else if (match_boot) begin
               entry.tail = KIND_BOOT;
            end else begin
               // An unknown or short command reports nothing.
               entry.tail = KIND_NONE;
            end
         end
      end
   end

   assign q_entry = entry;
   assign q_push  = fire && (entry.flash || entry.tail != KIND_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= KEY_RESET;
         mode_ff   <= 1'b0;
         lfsr_ff   <= 32'd1;
         size_ff   <= '0;
         offset_ff <= '0;
         pos_ff    <= '0;
      end else begin
         if (csr_wr_en) key_ff <= csr_wr_data;
         mode_ff   <= mode_in;
         lfsr_ff   <= lfsr_in;
         size_ff   <= size_in;
         offset_ff <= offset_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !mode_ff) begin
         for (int i = 0; i < CMD_DEPTH; i++) begin
            cmd_ff[i] <= cmd_view[i];
         end
      end
   end

endmodule

FILE: hdl/fdd_queue.sv
// Short result queue between the front end and the output stage.
// Depends on fdd_pkg for the entry type.
module fdd_queue
   import fdd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_entry,
   input  logic      pop,
   output entry_type rd_entry,
   output logic      full,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: hdl/fdd_back.sv
// Output stage: turns queue entries into one or two result beats.
// Depends on fdd_pkg; drains fdd_queue.
module fdd_back
   import fdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  entry_type   q_entry,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // flash_address, flash_byte
   output logic [2:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last_result
);

   logic        vld_ff, vld_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        pend_ff, pend_in;
   logic [2:0]  pend_kind_ff, pend_kind_in;
   logic        load;

   assign load  = !vld_ff || rsp_tready;
   assign q_pop = load && !pend_ff && !q_empty;

   always_comb begin
      vld_in       = vld_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      if (load) begin
         priority if (pend_ff) begin
            // Status result that follows a flash byte of the same input beat.
            vld_in  = 1'b1;
            kind_in = pend_kind_ff;
            addr_in = '0;
            data_in = '0;
            last_in = 1'b1;
            pend_in = 1'b0;
         end else if (!q_empty) begin
            vld_in = 1'b1;
            if (q_entry.flash) begin
               kind_in      = KIND_FLASH;
               addr_in      = q_entry.addr;
               data_in      = q_entry.data;
               last_in      = q_entry.tail == KIND_NONE;
               pend_in      = q_entry.tail != KIND_NONE;
               pend_kind_in = q_entry.tail;
            end else begin
               kind_in = q_entry.tail;
               addr_in = '0;
               data_in = '0;
               last_in = 1'b1;
            end
         end else begin
            vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
      last_ff      <= last_in;
      pend_kind_ff <= pend_kind_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {data_ff, addr_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: hdl/firmware_download_descrambler_unit.sv
// Firmware download descrambler. Accepts one packet byte per cycle while the
// queue is not full, parses FLASH, GETVERSION and BOOT commands at packet ends,
// and in download mode emits each byte XORed with a per-byte LFSR step together
// with its flash offset. A byte's parsing and descrambling finish in the cycle
// it is taken, so the input sustains one beat per cycle; results pass through a
// queue of QUEUE_DEPTH entries and then a registered output. A byte that ends
// the image yields a flash result and a done result, which take the output in
// turn; the queue absorbs such bursts, and the input stalls only while it is
// full. The scramble_key register is written through csr_wr_en and csr_wr_data.
// Depends on fdd_pkg, fdd_front, fdd_queue, fdd_back and the defines header.
`include "firmware_download_descrambler_unit_defines.svh"

module firmware_download_descrambler_unit
   import fdd_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,  // scramble_key
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte
   input  logic        req_tlast,    // last_in_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // flash_address [15:0], flash_byte [23:16]
   output logic [2:0]  rsp_tuser,    // result_kind
   output logic        rsp_tlast     // last_result
);

   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_in, q_out;

   fdd_front #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_in)
   );

   fdd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_entry(q_in),
      .pop     (q_pop),
      .rd_entry(q_out),
      .full    (q_full),
      .empty   (q_empty)
   );

   fdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   `FDD_ASSERT_IMPLY(a_push_has_result, clock, reset, q_push, q_in.flash || q_in.tail != KIND_NONE)
   `FDD_ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   `FDD_ASSERT_NEXT(a_push_fills, clock, reset, q_push, !q_empty)
   `FDD_ASSERT_IMPLY(a_status_zero, clock, reset, rsp_tvalid && rsp_tuser != KIND_FLASH, rsp_tdata == 24'd0 && rsp_tlast)

endmodule
